/* rtl/gws_pkg.sv */
// Package for the Gerstner wave surface point block: shared types, pipeline depths,
// the quarter-wave sine table and the sine lookup. No dependencies.
package gws_pkg;

  localparam int NUM_WAVES = 4;
  localparam int CFG_REGS  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CELL_LAT  = 10;
  localparam int SQRT_STG  = 32;
  localparam int DIV_STG   = 15;
  localparam int SIDE_N    = 3 + SQRT_STG + 1 + DIV_STG;
  localparam int NRM_LAT   = 6 + SIDE_N;

  localparam logic [27:0] TURN_SCALE   = 28'd170891319;
  localparam logic [63:0] QUARTER_STEP = 64'd6588397;
  localparam logic [63:0] PH_HALF      = 64'h0020_0000_0000_0000;
  localparam logic signed [63:0] ONE_Q40 = 64'sh0000_0100_0000_0000;
  localparam logic [14:0] UNIT_Q14 = 15'd16384;

  typedef struct packed {
    logic signed [63:0] px;
    logic signed [63:0] py;
    logic signed [63:0] pz;
    logic signed [63:0] nx;
    logic signed [63:0] ny;
    logic signed [63:0] nz;
    logic signed [63:0] ty;
    logic signed [63:0] txa;
    logic signed [63:0] tza;
  } gws_acc_t;

  typedef struct packed {
    logic               vld;
    logic signed [31:0] x;
    logic signed [31:0] z;
    logic        [31:0] t;
    gws_acc_t           acc;
  } gws_pass_t;

  typedef struct packed {
    logic             zero;
    logic [2:0]       neg;
    logic [2:0][30:0] aw;
  } gws_side_t;

  typedef logic [14:0] qsin_tab_t [0:256];

  function automatic qsin_tab_t build_qsin();
    qsin_tab_t          tab;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    for (int r = 0; r <= 256; r++) begin
      x    = 64'(r) * QUARTER_STEP;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int k = 1; k <= 5; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if ((k % 2) == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      v = (sum + 64'sd32768) >>> 16;
      tab[r] = (v > 64'sd16384) ? UNIT_Q14 : v[14:0];
    end
    return tab;
  endfunction

  localparam qsin_tab_t QSIN_TAB = build_qsin();

  function automatic logic signed [15:0] sine_q14(input logic [9:0] p);
    logic [14:0] v;
    v = p[8] ? QSIN_TAB[9'(9'd256 - {1'b0, p[7:0]})] : QSIN_TAB[{1'b0, p[7:0]}];
    return p[9] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

endpackage

/* rtl/gws_cell.sv */
// One wave cell of the chain: phase, sine and cosine lookup and the wave's terms,
// added onto the running sums handed on from the previous cell. Uses gws_pkg.
module gws_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [63:0]         wave_i,
  input  gws_pkg::gws_pass_t  pass_i,
  output gws_pkg::gws_pass_t  pass_o
);

  logic signed [11:0] dx;
  logic signed [11:0] dz;
  logic [9:0]         amp;
  logic [9:0]         spd;
  logic [9:0]         frq;
  logic [7:0]         stp;

  assign dx  = $signed(wave_i[11:0]);
  assign dz  = $signed(wave_i[23:12]);
  assign amp = wave_i[33:24];
  assign spd = wave_i[43:34];
  assign frq = wave_i[53:44];
  assign stp = wave_i[61:54];

  logic [17:0]        k_r;
  logic [19:0]        wa_r;
  logic [19:0]        cf_r;
  logic signed [20:0] qdx_r;
  logic signed [20:0] qdz_r;
  logic signed [30:0] kdx_r;
  logic signed [30:0] kdz_r;
  logic signed [22:0] qdxdz_r;
  logic signed [22:0] qdzdz_r;

  // Registered products of the wave parameters alone.
  always_ff @(posedge clk) begin
    k_r     <= stp * amp;
    wa_r    <= frq * amp;
    cf_r    <= spd * frq;
    qdx_r   <= $signed({1'b0, stp}) * dx;
    qdz_r   <= $signed({1'b0, stp}) * dz;
    kdx_r   <= $signed({1'b0, k_r}) * dx;
    kdz_r   <= $signed({1'b0, k_r}) * dz;
    qdxdz_r <= 23'((qdx_r * dz + 33'sd512) >>> 10);
    qdzdz_r <= 23'((qdz_r * dz + 33'sd512) >>> 10);
  end

  gws_pkg::gws_pass_t pipe_r [1:gws_pkg::CELL_LAT];
  gws_pkg::gws_pass_t last_nxt;

  logic signed [43:0] dxx_r;
  logic signed [43:0] dzz_r;
  logic [31:0]        t1_r;
  logic signed [44:0] sxz_r;
  logic [51:0]        ct2_r;
  logic signed [55:0] m_r;
  logic [51:0]        ct3_r;
  logic [63:0]        rad_r;
  logic [59:0]        phl_r;
  logic [31:0]        phh_r;
  logic [63:0]        ph;
  logic [9:0]         idx_r;
  logic signed [15:0] sin_r;
  logic signed [15:0] cos_r;
  logic signed [36:0] wc_r;
  logic signed [36:0] ws_r;
  logic signed [26:0] ys_r;
  logic signed [15:0] cos8_r;
  logic signed [46:0] tpx_r;
  logic signed [46:0] tpz_r;
  logic signed [26:0] tpy_r;
  logic signed [48:0] tnx_r;
  logic signed [48:0] tnz_r;
  logic signed [45:0] tny_r;
  logic signed [59:0] ttx_r;
  logic signed [59:0] ttz_r;

  assign ph = {4'b0, phl_r} + {phh_r, 32'd0} + gws_pkg::PH_HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      dxx_r  <= dx * pass_i.x;
      dzz_r  <= dz * pass_i.z;
      t1_r   <= pass_i.t;
      sxz_r  <= dxx_r + dzz_r;
      ct2_r  <= cf_r * t1_r;
      m_r    <= sxz_r * $signed({1'b0, frq});
      ct3_r  <= ct2_r;
      rad_r  <= 64'(m_r) + {10'd0, ct3_r, 2'b00};
      phl_r  <= rad_r[31:0] * gws_pkg::TURN_SCALE;
      phh_r  <= 32'(rad_r[63:32] * gws_pkg::TURN_SCALE);
      idx_r  <= ph[63:54];
      sin_r  <= gws_pkg::sine_q14(idx_r);
      cos_r  <= gws_pkg::sine_q14(idx_r + 10'd256);
      wc_r   <= $signed({1'b0, wa_r}) * cos_r;
      ws_r   <= $signed({1'b0, wa_r}) * sin_r;
      ys_r   <= $signed({1'b0, amp}) * sin_r;
      cos8_r <= cos_r;
      tpx_r  <= kdx_r * cos8_r;
      tpz_r  <= kdz_r * cos8_r;
      tpy_r  <= ys_r;
      tnx_r  <= dx * wc_r;
      tnz_r  <= dz * wc_r;
      tny_r  <= $signed({1'b0, stp}) * ws_r;
      ttx_r  <= qdxdz_r * ws_r;
      ttz_r  <= qdzdz_r * ws_r;
    end
  end

  always_comb begin
    last_nxt         = pipe_r[gws_pkg::CELL_LAT - 1];
    last_nxt.acc.px  = last_nxt.acc.px + 64'(tpx_r);
    last_nxt.acc.pz  = last_nxt.acc.pz + 64'(tpz_r);
    last_nxt.acc.py  = last_nxt.acc.py + (64'(tpy_r) <<< 18);
    last_nxt.acc.nx  = last_nxt.acc.nx + 64'(tnx_r);
    last_nxt.acc.nz  = last_nxt.acc.nz + 64'(tnz_r);
    last_nxt.acc.ny  = last_nxt.acc.ny + (64'(tny_r) <<< 2);
    last_nxt.acc.ty  = last_nxt.acc.ty + 64'(tnz_r);
    last_nxt.acc.txa = last_nxt.acc.txa + 64'(ttx_r);
    last_nxt.acc.tza = last_nxt.acc.tza + 64'(ttz_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= gws_pkg::CELL_LAT; k++) begin
        pipe_r[k].vld <= 1'b0;
      end
    end else if (en) begin
      pipe_r[1] <= pass_i;
      for (int k = 2; k < gws_pkg::CELL_LAT; k++) begin
        pipe_r[k] <= pipe_r[k - 1];
      end
      pipe_r[gws_pkg::CELL_LAT] <= last_nxt;
    end
  end

  assign pass_o = pipe_r[gws_pkg::CELL_LAT];

endmodule

/* rtl/gws_norm.sv */
// Pipelined vector normaliser: scaling shift, sum of squares, bit-serial square
// root stages and restoring divide stages giving a Q1.14 unit vector. Uses gws_pkg.
module gws_norm (
  input  logic               clk,
  input  logic               en,
  input  logic [1:0]         dflt_axis_i,
  input  logic signed [63:0] vec_i [3],
  output logic signed [15:0] unit_o [3]
);

  logic [63:0]        a_r [3];
  logic signed [63:0] v1_r [3];
  logic signed [63:0] v2_r [3];
  logic signed [63:0] v3_r [3];
  logic signed [63:0] v4_r [3];
  logic [63:0]        or_r;
  logic [7:0]         bnz_r;
  logic [7:0][2:0]    bhi_r;
  logic [7:0]         bnz;
  logic [7:0][2:0]    bhi;
  logic [6:0]         blen;
  logic [6:0]         blen_r;
  logic               z5_r;
  logic signed [31:0] w_r [3];
  gws_pkg::gws_side_t side_nxt;
  gws_pkg::gws_side_t side_r [0:gws_pkg::SIDE_N - 1];
  logic [59:0]        sq_r [3];
  logic [63:0]        sum_r;
  logic [63:0]        sqn_r [0:gws_pkg::SQRT_STG - 1];
  logic [63:0]        sqr_r [0:gws_pkg::SQRT_STG - 1];
  logic [30:0]        len_r [0:gws_pkg::DIV_STG];
  logic [45:0]        rem_r [0:gws_pkg::DIV_STG][3];
  logic [14:0]        quo_r [0:gws_pkg::DIV_STG][3];

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      bnz[b] = |or_r[8 * b +: 8];
      bhi[b] = 3'd0;
      for (int i = 0; i < 8; i++) begin
        if (or_r[8 * b + i]) begin
          bhi[b] = 3'(i);
        end
      end
    end
    blen = 7'd0;
    for (int b = 0; b < 8; b++) begin
      if (bnz_r[b]) begin
        blen = 7'(8 * b) + 7'(bhi_r[b]) + 7'd1;
      end
    end
  end

  always_comb begin
    side_nxt.zero = z5_r;
    for (int i = 0; i < 3; i++) begin
      side_nxt.neg[i] = w_r[i][31];
      side_nxt.aw[i]  = w_r[i][31] ? 31'(-w_r[i]) : w_r[i][30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_r[i]  <= vec_i[i][63] ? 64'(-vec_i[i]) : vec_i[i];
        v1_r[i] <= vec_i[i];
        v2_r[i] <= v1_r[i];
        v3_r[i] <= v2_r[i];
        v4_r[i] <= v3_r[i];
        if (blen_r > 7'd30) begin
          w_r[i] <= 32'(v4_r[i] >>> (blen_r - 7'd30));
        end else begin
          w_r[i] <= 32'(v4_r[i] <<< (7'd30 - blen_r));
        end
        sq_r[i] <= side_r[0].aw[i] * side_r[0].aw[i];
      end
      or_r   <= a_r[0] | a_r[1] | a_r[2];
      bnz_r  <= bnz;
      bhi_r  <= bhi;
      blen_r <= blen;
      z5_r   <= (blen_r == 7'd0);
      side_r[0] <= side_nxt;
      for (int k = 1; k < gws_pkg::SIDE_N; k++) begin
        side_r[k] <= side_r[k - 1];
      end
      sum_r <= 64'(sq_r[0]) + 64'(sq_r[1]) + 64'(sq_r[2]);
    end
  end

  // Square root, one result bit per stage, largest bit weight first.
  for (genvar k = 0; k < gws_pkg::SQRT_STG; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (2 * (gws_pkg::SQRT_STG - 1 - k));
    logic [63:0] n_in;
    logic [63:0] r_in;
    if (k == 0) begin : g_first
      assign n_in = sum_r;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = sqn_r[k - 1];
      assign r_in = sqr_r[k - 1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (n_in >= r_in + BIT) begin
          sqn_r[k] <= n_in - (r_in + BIT);
          sqr_r[k] <= (r_in >> 1) + BIT;
        end else begin
          sqn_r[k] <= n_in;
          sqr_r[k] <= r_in >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_r[0] <= sqr_r[gws_pkg::SQRT_STG - 1][30:0];
      for (int i = 0; i < 3; i++) begin
        rem_r[0][i] <= {1'b0, side_r[gws_pkg::SQRT_STG + 2].aw[i], 14'd0}
                       + 46'(sqr_r[gws_pkg::SQRT_STG - 1][30:1]);
        quo_r[0][i] <= '0;
      end
    end
  end

  // Restoring divide, one quotient bit per stage.
  for (genvar j = 1; j <= gws_pkg::DIV_STG; j++) begin : g_div
    localparam int SH = gws_pkg::DIV_STG - j;
    logic [45:0] dvs;
    assign dvs = 46'(len_r[j - 1]) << SH;
    always_ff @(posedge clk) begin
      if (en) begin
        len_r[j] <= len_r[j - 1];
        for (int i = 0; i < 3; i++) begin
          if (rem_r[j - 1][i] >= dvs) begin
            rem_r[j][i] <= rem_r[j - 1][i] - dvs;
            quo_r[j][i] <= quo_r[j - 1][i] | (15'd1 << SH);
          end else begin
            rem_r[j][i] <= rem_r[j - 1][i];
            quo_r[j][i] <= quo_r[j - 1][i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [14:0] mag;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag = (quo_r[gws_pkg::DIV_STG][i] > gws_pkg::UNIT_Q14) ?
              gws_pkg::UNIT_Q14 : quo_r[gws_pkg::DIV_STG][i];
        if (side_r[gws_pkg::SIDE_N - 1].zero) begin
          unit_o[i] <= (dflt_axis_i == 2'(i)) ? $signed({1'b0, gws_pkg::UNIT_Q14}) : 16'sd0;
        end else if (side_r[gws_pkg::SIDE_N - 1].neg[i]) begin
          unit_o[i] <= -$signed({1'b0, mag});
        end else begin
          unit_o[i] <= $signed({1'b0, mag});
        end
      end
    end
  end

endmodule

/* rtl/gerstner_wave_surface_point.sv */
// Top level of the Gerstner wave surface point block: wave registers, the chain of
// wave cells, final sums and the two normalisers. Uses gws_pkg, gws_cell, gws_norm.
//
//  channel  direction  contents
//  in_      slave      point_x, point_z, time_now
//  out_     master     disp_x/y/z, norm_x/y/z, tan_x/y/z
//  cfg_     write      wave_zero .. wave_three
//
// One point is taken per cycle while no result waits on out_tready; the path runs through
// the wave cells (4 cells), a register of final sums and then the normalisers.
// Most of the normaliser depth lies in its square root and divide stages.
// Reset clears the wave registers and every valid bit. The whole pipeline holds
// while a result waits on out_tready.
module gerstner_wave_surface_point (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [95:0]                   in_tdata,   // point_x, point_z, time_now
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [191:0]                  out_tdata,  // disp_x, disp_y, disp_z, norm_x,
                                                    // norm_y, norm_z, tan_x, tan_y, tan_z
  input  logic                          cfg_wr_en,
  input  logic [gws_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_wdata
);

  typedef struct packed {
    logic signed [31:0] dz;
    logic signed [31:0] dy;
    logic signed [31:0] dx;
  } disp_t;

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    if (v > 41'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -41'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  logic               en;
  logic [63:0]        wave_r [gws_pkg::NUM_WAVES];
  gws_pkg::gws_pass_t chain [0:gws_pkg::NUM_WAVES];
  gws_pkg::gws_pass_t fin;
  logic               post_vld_r;
  logic signed [63:0] nv_r [3];
  logic signed [63:0] tv_r [3];
  disp_t              post_r;
  disp_t              dly_r [0:gws_pkg::NRM_LAT - 1];
  logic [gws_pkg::NRM_LAT-1:0] vl_r;
  logic signed [15:0] nrm_o [3];
  logic signed [15:0] tan_o [3];

  assign out_tvalid = vl_r[gws_pkg::NRM_LAT - 1];
  assign en         = !out_tvalid || out_tready;
  assign in_tready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gws_pkg::NUM_WAVES; i++) begin
        wave_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      for (int i = 0; i < gws_pkg::NUM_WAVES; i++) begin
        if (int'(cfg_index) == i && i < gws_pkg::CFG_REGS) begin
          wave_r[i] <= cfg_wdata;
        end
      end
    end
  end

  always_comb begin
    chain[0].vld = in_tvalid && in_tready;
    chain[0].x   = $signed(in_tdata[31:0]);
    chain[0].z   = $signed(in_tdata[63:32]);
    chain[0].t   = in_tdata[95:64];
    chain[0].acc = '0;
  end

  for (genvar i = 0; i < gws_pkg::NUM_WAVES; i++) begin : g_cell
    gws_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .wave_i (wave_r[i]),
      .pass_i (chain[i]),
      .pass_o (chain[i + 1])
    );
  end

  assign fin = chain[gws_pkg::NUM_WAVES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      post_vld_r <= 1'b0;
      vl_r       <= '0;
    end else if (en) begin
      post_vld_r <= fin.vld;
      vl_r       <= {vl_r[gws_pkg::NRM_LAT-2:0], post_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nv_r[0]   <= -fin.acc.nx;
      nv_r[1]   <= gws_pkg::ONE_Q40 - fin.acc.ny;
      nv_r[2]   <= -fin.acc.nz;
      tv_r[0]   <= -((fin.acc.txa + 64'sd128) >>> 8);
      tv_r[1]   <= fin.acc.ty;
      tv_r[2]   <= gws_pkg::ONE_Q40 - ((fin.acc.tza + 64'sd128) >>> 8);
      post_r.dx <= sat32(41'(fin.x) + 41'((fin.acc.px + 64'sd8388608) >>> 24));
      post_r.dy <= sat32(41'((fin.acc.py + 64'sd8388608) >>> 24));
      post_r.dz <= sat32(41'(fin.z) + 41'((fin.acc.pz + 64'sd8388608) >>> 24));
      dly_r[0]  <= post_r;
      for (int k = 1; k < gws_pkg::NRM_LAT; k++) begin
        dly_r[k] <= dly_r[k - 1];
      end
    end
  end

  gws_norm u_nrm (
    .clk         (clk),
    .en          (en),
    .dflt_axis_i (2'd1),
    .vec_i       (nv_r),
    .unit_o      (nrm_o)
  );

  gws_norm u_tan (
    .clk         (clk),
    .en          (en),
    .dflt_axis_i (2'd2),
    .vec_i       (tv_r),
    .unit_o      (tan_o)
  );

  assign out_tdata = {tan_o[2], tan_o[1], tan_o[0], nrm_o[2], nrm_o[1], nrm_o[0],
                      dly_r[gws_pkg::NRM_LAT - 1].dz, dly_r[gws_pkg::NRM_LAT - 1].dy,
                      dly_r[gws_pkg::NRM_LAT - 1].dx};

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vl_r) && $stable(post_vld_r))
    else $error("valid line moved during a stall");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> nrm_o[0] >= -16'sd16384 && nrm_o[0] <= 16'sd16384 &&
                   nrm_o[1] >= -16'sd16384 && nrm_o[1] <= 16'sd16384 &&
                   nrm_o[2] >= -16'sd16384 && nrm_o[2] <= 16'sd16384 &&
                   tan_o[0] >= -16'sd16384 && tan_o[0] <= 16'sd16384 &&
                   tan_o[1] >= -16'sd16384 && tan_o[1] <= 16'sd16384 &&
                   tan_o[2] >= -16'sd16384 && tan_o[2] <= 16'sd16384)
    else $error("unit vector component out of range");

endmodule

/* sim/tb_gerstner_wave_surface_point.sv */
// Testbench for the Gerstner wave surface point block: drives points through the
// stream input, predicts each result with its own fixed-point model and checks it.
// Depends on gws_pkg and gerstner_wave_surface_point.
module tb_gerstner_wave_surface_point;

  typedef struct packed {
    logic [31:0] t;
    logic [31:0] z;
    logic [31:0] x;
  } point_t;

  typedef struct packed {
    logic [15:0] tz;
    logic [15:0] ty;
    logic [15:0] tx;
    logic [15:0] nz;
    logic [15:0] ny;
    logic [15:0] nx;
    logic [31:0] dz;
    logic [31:0] dy;
    logic [31:0] dx;
  } surf_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [95:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [191:0] out_tdata;
  logic cfg_wr_en;
  logic [gws_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_wdata;

  logic [63:0] wave_cfg [0:3];
  point_t point_q [$];
  surf_t surface_q [$];
  logic in_taken;
  int mismatches;
  int burst_left;
  int gap_left;
  int stall_mode;
  int total_sent;

  gerstner_wave_surface_point uut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400000000;
    $display("[gerstner_wave_surface_point] ERROR");
    $finish;
  end

  function automatic longint asr_floor(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint asr_round(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint quarter_sin(int r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint sum;
    longint v;
    x = 64'(r) * 64'd6588397;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= 5; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    v = (sum + 32768) >>> 16;
    return (v > 16384) ? 64'sd16384 : v;
  endfunction

  function automatic longint table_sin(logic [63:0] p);
    logic [9:0] pp;
    longint v;
    pp = p[9:0];
    v = pp[8] ? quarter_sin(256 - int'(pp[7:0])) : quarter_sin(int'(pp[7:0]));
    return pp[9] ? -v : v;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void normalise(input longint v [3], input longint dflt [3],
                                    output longint o [3]);
    logic [63:0] m;
    logic [63:0] sq;
    logic [63:0] len;
    logic [63:0] a;
    logic [63:0] mag;
    longint w [3];
    int n;
    m = 0;
    sq = 0;
    n = 0;
    for (int i = 0; i < 3; i++) begin
      a = v[i] < 0 ? -v[i] : v[i];
      if (a > m) m = a;
    end
    if (m == 0) begin
      o = dflt;
      return;
    end
    if (m >= (64'd1 << 30)) begin
      while ((m >> n) >= (64'd1 << 30)) n++;
      for (int i = 0; i < 3; i++) w[i] = asr_floor(v[i], n);
    end else begin
      while ((m << n) < (64'd1 << 29)) n++;
      for (int i = 0; i < 3; i++) w[i] = v[i] <<< n;
    end
    for (int i = 0; i < 3; i++) begin
      a = w[i] < 0 ? -w[i] : w[i];
      sq += a * a;
    end
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      a = w[i] < 0 ? -w[i] : w[i];
      mag = (a * 16384 + len / 2) / len;
      if (mag > 16384) mag = 16384;
      o[i] = w[i] < 0 ? -longint'(mag) : longint'(mag);
    end
  endfunction

  function automatic surf_t surface_point(point_t p);
    longint x, z, dx, dz, amp, f, q, rad, s, co, k, wa, wc, ws;
    logic [63:0] t, c, ph, idx;
    longint px, py, pz, nx, ny, nz, ty, txa, tza;
    longint nv [3];
    longint tv [3];
    longint nr [3];
    longint tr [3];
    longint up [3];
    longint fwd [3];
    surf_t r;
    x = longint'($signed(p.x));
    z = longint'($signed(p.z));
    t = 64'(p.t);
    {px, py, pz, nx, ny, nz, ty, txa, tza} = '0;
    up = '{0, 16384, 0};
    fwd = '{0, 0, 16384};
    for (int i = 0; i < gws_pkg::NUM_WAVES; i++) begin
      dx = longint'($signed(wave_cfg[i][11:0]));
      dz = longint'($signed(wave_cfg[i][23:12]));
      amp = longint'(wave_cfg[i][33:24]);
      c = 64'(wave_cfg[i][43:34]);
      f = longint'(wave_cfg[i][53:44]);
      q = longint'(wave_cfg[i][61:54]);
      rad = (dx * x + dz * z) * f + longint'(c * 64'(f) * t) * 4;
      ph = 64'(rad) * 64'd170891319;
      idx = (ph + (64'd1 << 53)) >> 54;
      s = table_sin(idx);
      co = table_sin(idx + 256);
      k = q * amp;
      wa = f * amp;
      wc = wa * co;
      ws = wa * s;
      px += k * dx * co;
      pz += k * dz * co;
      py += amp * s * 262144;
      nx += dx * wc;
      nz += dz * wc;
      ny += q * ws * 4;
      ty += dz * wc;
      txa += asr_round(q * dx * dz, 10) * ws;
      tza += asr_round(q * dz * dz, 10) * ws;
    end
    nv = '{-nx, (64'sd1 <<< 40) - ny, -nz};
    tv = '{-asr_round(txa, 8), ty, (64'sd1 <<< 40) - asr_round(tza, 8)};
    normalise(nv, up, nr);
    normalise(tv, fwd, tr);
    r.dx = 32'(sat32(x + asr_round(px, 24)));
    r.dy = 32'(sat32(asr_round(py, 24)));
    r.dz = 32'(sat32(z + asr_round(pz, 24)));
    r.nx = 16'(nr[0]);
    r.ny = 16'(nr[1]);
    r.nz = 16'(nr[2]);
    r.tx = 16'(tr[0]);
    r.ty = 16'(tr[1]);
    r.tz = 16'(tr[2]);
    return r;
  endfunction

  // Input monitor: a transfer records its prediction at the accepting edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        surface_q.push_back(surface_point(point_t'(in_tdata)));
        total_sent <= total_sent + 1;
      end
    end
  end

  // Sender: bursts and gaps, plus random out_tready stalls; a new item is offered once the previous one is taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (point_q.size() > 0) begin
          in_tdata <= 96'(point_q.pop_front());
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 2) == 0);
      endcase
      if ($urandom_range(0, 60) == 0) stall_mode <= $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    surf_t got;
    surf_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = surf_t'(out_tdata);
      if (surface_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %h", got);
      end else begin
        want = surface_q.pop_front();
        if (got.dx !== want.dx || got.dy !== want.dy || got.dz !== want.dz ||
            got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz ||
            got.tx !== want.tx || got.ty !== want.ty || got.tz !== want.tz) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch disp exp %h %h %h got %h %h %h",
                     want.dx, want.dy, want.dz, got.dx, got.dy, got.dz);
            $display("  norm exp %h %h %h got %h %h %h tan exp %h %h %h got %h %h %h",
                     want.nx, want.ny, want.nz, got.nx, got.ny, got.nz,
                     want.tx, want.ty, want.tz, got.tx, got.ty, got.tz);
          end
        end
      end
    end
  end

  function automatic logic [63:0] rand_wave(int kind);
    logic [63:0] w;
    w = {$urandom, $urandom};
    // Kind 1 gives tame waves (smaller amplitude and frequency) so heights and normals stay interesting.
    if (kind == 1) begin
      w[33:32] = 2'b00;
      w[53:50] = 4'b0000;
    end
    return w;
  endfunction

  task automatic write_wave(int i, logic [63:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= i[gws_pkg::CFG_IDX_W-1:0];
    cfg_wdata <= v;
    wave_cfg[i] = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    while (point_q.size() > 0 || in_tvalid || surface_q.size() > 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic point_t rand_point(int narrow);
    point_t p;
    p = {$urandom, $urandom, $urandom};
    if (narrow) begin
      p.x = 32'($signed(p.x) >>> 8);
      p.z = 32'($signed(p.z) >>> 8);
    end
    return p;
  endfunction

  initial begin
    point_t p;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    mismatches = 0;
    burst_left = 0;
    gap_left = 0;
    stall_mode = 0;
    total_sent = 0;
    for (int i = 0; i < 4; i++) wave_cfg[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero waves give the default normal and tangent.
    point_q.push_back('{32'h0, 32'h0, 32'h0});
    point_q.push_back('{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
    drain();

    write_wave(0, {2'b00, 8'hFF, 10'h100, 10'h080, 10'h100, 12'h000, 12'h400});
    write_wave(1, {2'b11, 8'h80, 10'h3FF, 10'h3FF, 10'h3FF, 12'h800, 12'h7FF});
    write_wave(2, {2'b00, 8'h40, 10'h040, 10'h100, 10'h200, 12'h2D4, 12'hD2C});
    write_wave(3, 64'hFFFF_FFFF_FFFF_FFFF);
    point_q.push_back('{32'h0, 32'h0, 32'h0});
    point_q.push_back('{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    point_q.push_back('{32'h0, 32'h8000_0000, 32'h8000_0000});
    point_q.push_back('{32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    point_q.push_back('{32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000});
    for (int i = 0; i < 10; i++) point_q.push_back(rand_point(0));
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      for (int i = 0; i < 4; i++) begin
        if (phase == 5) write_wave(i, 64'h0);
        else if (phase == 4 && i == 2) write_wave(i, 64'hFFFF_FFFF_FFFF_FFFF);
        else write_wave(i, rand_wave(phase % 2));
      end
      for (int n = 0; n < 240; n++) begin
        p = rand_point($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 15) == 0) p.t = 32'hFFFF_FFFF;
        point_q.push_back(p);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("[gerstner_wave_surface_point] OK");
    end else begin
      $display("[gerstner_wave_surface_point] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/gws_pkg.sv
rtl/gws_cell.sv
rtl/gws_norm.sv
rtl/gerstner_wave_surface_point.sv
sim/tb_gerstner_wave_surface_point.sv
